>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked at every rising edge outside reset
`define ASSERT_IMPLY(name, clk, rst, cond, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("same-cycle implication violated");

// Next-cycle implication, checked at every rising edge outside reset
`define ASSERT_NEXT(name, clk, rst, cond, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("next-cycle implication violated");

`else

`define ASSERT_IMPLY(name, clk, rst, cond, expr)
`define ASSERT_NEXT(name, clk, rst, cond, expr)

`endif

`endif

>>> rtl/core/tjsf_pkg.sv
// ----------------------------------------------------------------------------
// tjsf_pkg
// Widths, fixed-point constants, stage payload types and the divider step.
// ----------------------------------------------------------------------------
package tjsf_pkg;

  // Field widths
  localparam int ANGLE_W   = 18;
  localparam int RATE_W    = 18;
  localparam int PERIOD_W  = 16;
  localparam int GAIN_W    = 24;
  localparam int EFFORT_W  = 20;

  // Gain bank: two rows of four terms
  localparam int NUM_GAINS     = 8;
  localparam int ROWS          = 2;
  localparam int GAINS_PER_ROW = 4;
  localparam int REG_IDX_W     = 3;
  localparam int TERM_POS1     = 0;
  localparam int TERM_POS2     = 1;
  localparam int TERM_VEL1     = 2;
  localparam int TERM_VEL2     = 3;
  localparam int JOINTS        = 2;

  // Angle wrap: pi in Q5.13; offset keeps the shifted error positive
  localparam int PI_Q13      = 25736;
  localparam int TWO_PI      = 2 * PI_Q13;
  localparam int WRAP_W      = 20;
  localparam int WRAP_STEPS  = 4;
  localparam int WRAP_OFS    = PI_Q13 - 1 + 6 * TWO_PI;
  localparam int WRAPPED_W   = 16;
  localparam int DERR_W      = WRAPPED_W + 1;
  localparam int ABS_W       = 15;

  // Divide by ten through a reciprocal
  localparam int DIVISOR_TEN = 10;
  localparam int ROUND_TEN   = DIVISOR_TEN / 2;
  localparam int DIV10_SHIFT = 18;
  localparam int DIV10_MUL   = ((1 << DIV10_SHIFT) + DIVISOR_TEN - 1) / DIVISOR_TEN;
  localparam int PROD10_W    = 30;
  localparam int Q10_W       = PROD10_W - DIV10_SHIFT;
  localparam int POS_W       = 19;

  // Rate correction divider
  localparam int RATE_SCALE  = 12500;
  localparam int NUM_W       = 29;
  localparam int DIV_W       = 32;
  localparam int DIV_BITS    = 4;
  localparam int DIV_STAGES  = DIV_W / DIV_BITS;
  localparam int VEL_W       = 30;

  // Effort accumulation, Q.27 aligned
  localparam int PP_W        = GAIN_W + POS_W;
  localparam int PV_W        = GAIN_W + VEL_W;
  localparam int ACC_W       = 60;
  localparam int VEL_ALIGN   = 3;
  localparam int ROUND_SHIFT = 17;
  localparam int ROUND_BIAS  = 1 << (ROUND_SHIFT - 1);
  localparam int EFFORT_MAX  = 524287;
  localparam int EFFORT_MIN  = -524288;

  typedef logic [NUM_GAINS-1:0][GAIN_W-1:0] gain_bank_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0]  angle_one;
    logic signed [ANGLE_W-1:0]  angle_two;
    logic signed [RATE_W-1:0]   rate_one;
    logic signed [RATE_W-1:0]   rate_two;
    logic signed [ANGLE_W-1:0]  target_one;
    logic signed [ANGLE_W-1:0]  target_two;
    logic        [PERIOD_W-1:0] period_us;
  } in_item_t;

  // Per-item data that rides along the divider
  typedef struct packed {
    logic signed [POS_W-1:0]  pos_one;
    logic signed [POS_W-1:0]  pos_two;
    logic signed [RATE_W-1:0] rate_one;
    logic signed [RATE_W-1:0] rate_two;
    logic                     neg_one;
    logic                     neg_two;
  } side_t;

  typedef struct packed {
    side_t                side;
    logic [NUM_W-1:0]     num_one;
    logic [NUM_W-1:0]     num_two;
    logic [PERIOD_W-1:0]  den;
  } div_in_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_one;
    logic signed [POS_W-1:0] pos_two;
    logic signed [VEL_W-1:0] vel_one;
    logic signed [VEL_W-1:0] vel_two;
  } state_t;

  typedef struct packed {
    logic signed [EFFORT_W-1:0] effort_one;
    logic signed [EFFORT_W-1:0] effort_two;
    logic                       clipped;
  } res_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] rem;
    logic [DIV_BITS-1:0] q;
  } div_step_t;

  // Restoring division over DIV_BITS numerator bits
  function automatic div_step_t div_step(input logic [PERIOD_W-1:0] rem,
                                         input logic [DIV_BITS-1:0] bits,
                                         input logic [PERIOD_W-1:0] den);
    logic [PERIOD_W:0] r;
    div_step_t         res;
    r     = {1'b0, rem};
    res.q = '0;
    for (int i = DIV_BITS - 1; i >= 0; i--) begin
      r = {r[PERIOD_W-1:0], bits[i]};
      if (r >= {1'b0, den}) begin
        r        = r - {1'b0, den};
        res.q[i] = 1'b1;
      end
    end
    res.rem = r[PERIOD_W-1:0];
    return res;
  endfunction

endpackage

>>> rtl/core/tjsf_front.sv
// ----------------------------------------------------------------------------
// tjsf_front
// Wraps each angle error into (-pi, pi], shifts the position by d/10 and
// forms the rounded numerator of the rate correction. Four register stages.
// ----------------------------------------------------------------------------
module tjsf_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  tjsf_pkg::in_item_t  in_item,
  output logic                out_valid,
  output tjsf_pkg::div_in_t   out_data
);

  localparam int LANES = tjsf_pkg::JOINTS;

  logic signed [tjsf_pkg::ANGLE_W-1:0] ang_in [LANES];
  logic signed [tjsf_pkg::ANGLE_W-1:0] tgt_in [LANES];
  logic signed [tjsf_pkg::RATE_W-1:0]  rate_in [LANES];

  // stage 1 registers
  logic                                v1;
  logic signed [tjsf_pkg::ANGLE_W-1:0] ang1 [LANES];
  logic signed [tjsf_pkg::RATE_W-1:0]  rate1 [LANES];
  logic        [tjsf_pkg::PERIOD_W-1:0] den1;
  logic        [tjsf_pkg::WRAP_W-1:0]  y1 [LANES];

  // stage 2 registers
  logic                                v2;
  logic signed [tjsf_pkg::ANGLE_W-1:0] ang2 [LANES];
  logic signed [tjsf_pkg::RATE_W-1:0]  rate2 [LANES];
  logic        [tjsf_pkg::PERIOD_W-1:0] den2;
  logic        [tjsf_pkg::ABS_W-1:0]   abs2 [LANES];
  logic                                neg2 [LANES];

  // stage 3 registers
  logic                                v3;
  logic signed [tjsf_pkg::ANGLE_W-1:0] ang3 [LANES];
  logic signed [tjsf_pkg::RATE_W-1:0]  rate3 [LANES];
  logic        [tjsf_pkg::PERIOD_W-1:0] den3;
  logic                                neg3 [LANES];
  logic        [tjsf_pkg::Q10_W-1:0]   q10_3 [LANES];
  logic        [tjsf_pkg::NUM_W-1:0]   num3 [LANES];

  // combinational results per stage
  logic        [tjsf_pkg::WRAP_W-1:0]   y1_next [LANES];
  logic        [tjsf_pkg::PERIOD_W-1:0] den1_next;
  logic        [tjsf_pkg::ABS_W-1:0]    abs2_next [LANES];
  logic                                 neg2_next [LANES];
  logic        [tjsf_pkg::Q10_W-1:0]    q10_3_next [LANES];
  logic        [tjsf_pkg::NUM_W-1:0]    num3_next [LANES];
  logic signed [tjsf_pkg::POS_W-1:0]    pos4_next [LANES];

  // Split the beat into lanes
  always_comb begin
    ang_in[0]  = in_item.angle_one;
    ang_in[1]  = in_item.angle_two;
    tgt_in[0]  = in_item.target_one;
    tgt_in[1]  = in_item.target_two;
    rate_in[0] = in_item.rate_one;
    rate_in[1] = in_item.rate_two;
  end

  // Stage 1: offset angle error, zero period taken as one
  always_comb begin
    logic signed [tjsf_pkg::WRAP_W:0] ysum;
    ysum = '0;
    for (int l = 0; l < LANES; l++) begin
      ysum = (tjsf_pkg::WRAP_W + 1)'(ang_in[l]) - (tjsf_pkg::WRAP_W + 1)'(tgt_in[l])
           + (tjsf_pkg::WRAP_W + 1)'(tjsf_pkg::WRAP_OFS);
      y1_next[l] = ysum[tjsf_pkg::WRAP_W-1:0];
    end
    den1_next = (in_item.period_us == '0) ? tjsf_pkg::PERIOD_W'(1) : in_item.period_us;
  end

  // Stage 2: reduce modulo two pi, recenter, split sign and magnitude
  always_comb begin
    logic        [tjsf_pkg::WRAP_W-1:0] m;
    logic signed [tjsf_pkg::DERR_W-1:0] dval;
    logic signed [tjsf_pkg::DERR_W-1:0] dmag;
    m    = '0;
    dval = '0;
    dmag = '0;
    for (int l = 0; l < LANES; l++) begin
      m = y1[l];
      for (int s = tjsf_pkg::WRAP_STEPS - 1; s >= 0; s--) begin
        if (m >= tjsf_pkg::WRAP_W'(tjsf_pkg::TWO_PI * (1 << s))) begin
          m = m - tjsf_pkg::WRAP_W'(tjsf_pkg::TWO_PI * (1 << s));
        end
      end
      dval = $signed({1'b0, m[tjsf_pkg::WRAPPED_W-1:0]})
           - tjsf_pkg::DERR_W'(tjsf_pkg::PI_Q13 - 1);
      dmag = dval[tjsf_pkg::DERR_W-1] ? -dval : dval;
      neg2_next[l] = dval[tjsf_pkg::DERR_W-1];
      abs2_next[l] = dmag[tjsf_pkg::ABS_W-1:0];
    end
  end

  // Stage 3: |d|/10 by reciprocal, rate numerator with half-divisor rounding
  always_comb begin
    logic [tjsf_pkg::ABS_W:0]      abs_r;
    logic [tjsf_pkg::PROD10_W-1:0] p10;
    abs_r = '0;
    p10   = '0;
    for (int l = 0; l < LANES; l++) begin
      abs_r = {1'b0, abs2[l]} + (tjsf_pkg::ABS_W + 1)'(tjsf_pkg::ROUND_TEN);
      p10   = tjsf_pkg::PROD10_W'(abs_r * tjsf_pkg::DIV10_MUL);
      q10_3_next[l] = p10[tjsf_pkg::PROD10_W-1:tjsf_pkg::DIV10_SHIFT];
      num3_next[l]  = tjsf_pkg::NUM_W'(abs2[l] * tjsf_pkg::RATE_SCALE)
                    + tjsf_pkg::NUM_W'(den2 >> 1);
    end
  end

  // Stage 4: shifted position, sign restored
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      pos4_next[l] = neg3[l]
                   ? tjsf_pkg::POS_W'(ang3[l]) + tjsf_pkg::POS_W'(q10_3[l])
                   : tjsf_pkg::POS_W'(ang3[l]) - tjsf_pkg::POS_W'(q10_3[l]);
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  // Payload registers, held on stall
  always_ff @(posedge clk) begin
    if (adv) begin
      den1 <= den1_next;
      den2 <= den1;
      den3 <= den2;
      for (int l = 0; l < LANES; l++) begin
        ang1[l]  <= ang_in[l];
        rate1[l] <= rate_in[l];
        y1[l]    <= y1_next[l];
        ang2[l]  <= ang1[l];
        rate2[l] <= rate1[l];
        abs2[l]  <= abs2_next[l];
        neg2[l]  <= neg2_next[l];
        ang3[l]  <= ang2[l];
        rate3[l] <= rate2[l];
        neg3[l]  <= neg2[l];
        q10_3[l] <= q10_3_next[l];
        num3[l]  <= num3_next[l];
      end
      out_data.side.pos_one  <= pos4_next[0];
      out_data.side.pos_two  <= pos4_next[1];
      out_data.side.rate_one <= rate3[0];
      out_data.side.rate_two <= rate3[1];
      out_data.side.neg_one  <= neg3[0];
      out_data.side.neg_two  <= neg3[1];
      out_data.num_one       <= num3[0];
      out_data.num_two       <= num3[1];
      out_data.den           <= den3;
    end
  end

endmodule

>>> rtl/core/tjsf_rate_div.sv
// ----------------------------------------------------------------------------
// tjsf_rate_div
// Pipelined restoring divider, four quotient bits per stage on both joints,
// followed by the stage that applies the rate correction to the velocity.
// ----------------------------------------------------------------------------
module tjsf_rate_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  tjsf_pkg::div_in_t  in_data,
  output logic               out_valid,
  output tjsf_pkg::state_t   out_state
);

  localparam int LANES = tjsf_pkg::JOINTS;
  localparam int LAST  = tjsf_pkg::DIV_STAGES - 1;

  logic                          stg_valid [tjsf_pkg::DIV_STAGES];
  tjsf_pkg::side_t               stg_side  [tjsf_pkg::DIV_STAGES];
  logic [tjsf_pkg::PERIOD_W-1:0] stg_den   [tjsf_pkg::DIV_STAGES];
  logic [tjsf_pkg::DIV_W-1:0]    stg_work  [tjsf_pkg::DIV_STAGES][LANES];
  logic [tjsf_pkg::PERIOD_W-1:0] stg_rem   [tjsf_pkg::DIV_STAGES][LANES];

  logic [tjsf_pkg::NUM_W-1:0]    quo   [LANES];
  logic signed [tjsf_pkg::VEL_W-1:0] vel_next [LANES];
  logic signed [tjsf_pkg::RATE_W-1:0] rate_last [LANES];
  logic                          neg_last  [LANES];

  for (genvar k = 0; k < tjsf_pkg::DIV_STAGES; k++) begin : g_stage
    logic                          src_valid;
    tjsf_pkg::side_t               src_side;
    logic [tjsf_pkg::PERIOD_W-1:0] src_den;
    logic [tjsf_pkg::DIV_W-1:0]    src_work [LANES];
    logic [tjsf_pkg::PERIOD_W-1:0] src_rem  [LANES];
    tjsf_pkg::div_step_t           step     [LANES];

    // Select the stage input: the new beat or the previous stage
    if (k == 0) begin : g_head
      always_comb begin
        src_valid   = in_valid;
        src_side    = in_data.side;
        src_den     = in_data.den;
        src_work[0] = tjsf_pkg::DIV_W'(in_data.num_one);
        src_work[1] = tjsf_pkg::DIV_W'(in_data.num_two);
        src_rem[0]  = '0;
        src_rem[1]  = '0;
      end
    end else begin : g_body
      always_comb begin
        src_valid = stg_valid[k-1];
        src_side  = stg_side[k-1];
        src_den   = stg_den[k-1];
        for (int l = 0; l < LANES; l++) begin
          src_work[l] = stg_work[k-1][l];
          src_rem[l]  = stg_rem[k-1][l];
        end
      end
    end

    // Retire the top numerator bits into the quotient
    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        step[l] = tjsf_pkg::div_step(src_rem[l],
                    src_work[l][tjsf_pkg::DIV_W-1 -: tjsf_pkg::DIV_BITS], src_den);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stg_valid[k] <= 1'b0;
      end else if (adv) begin
        stg_valid[k] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        stg_side[k] <= src_side;
        stg_den[k]  <= src_den;
        for (int l = 0; l < LANES; l++) begin
          stg_rem[k][l]  <= step[l].rem;
          stg_work[k][l] <= {src_work[l][tjsf_pkg::DIV_W-tjsf_pkg::DIV_BITS-1:0],
                             step[l].q};
        end
      end
    end
  end

  // Velocity minus signed correction
  always_comb begin
    rate_last[0] = stg_side[LAST].rate_one;
    rate_last[1] = stg_side[LAST].rate_two;
    neg_last[0]  = stg_side[LAST].neg_one;
    neg_last[1]  = stg_side[LAST].neg_two;
    for (int l = 0; l < LANES; l++) begin
      quo[l]      = stg_work[LAST][l][tjsf_pkg::NUM_W-1:0];
      vel_next[l] = neg_last[l]
                  ? tjsf_pkg::VEL_W'(rate_last[l]) + tjsf_pkg::VEL_W'(quo[l])
                  : tjsf_pkg::VEL_W'(rate_last[l]) - tjsf_pkg::VEL_W'(quo[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= stg_valid[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_state.pos_one <= stg_side[LAST].pos_one;
      out_state.pos_two <= stg_side[LAST].pos_two;
      out_state.vel_one <= vel_next[0];
      out_state.vel_two <= vel_next[1];
    end
  end

endmodule

>>> rtl/core/tjsf_effort.sv
// ----------------------------------------------------------------------------
// tjsf_effort
// Applies the 2x4 gain matrix to the shifted state, negates, rounds to
// Q10.10 and saturates. Multiply, two add stages, round and clamp stage.
// ----------------------------------------------------------------------------
module tjsf_effort (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  tjsf_pkg::gain_bank_t gains,
  input  logic                 in_valid,
  input  tjsf_pkg::state_t     in_state,
  output logic                 out_valid,
  output tjsf_pkg::res_t       out_res
);

  localparam int ROWS = tjsf_pkg::ROWS;

  logic signed [tjsf_pkg::POS_W-1:0]  pos_a [tjsf_pkg::JOINTS];
  logic signed [tjsf_pkg::VEL_W-1:0]  vel_a [tjsf_pkg::JOINTS];
  logic signed [tjsf_pkg::GAIN_W-1:0] g [ROWS][tjsf_pkg::GAINS_PER_ROW];

  logic                               v1, v2, v3;
  logic signed [tjsf_pkg::PP_W-1:0]   pp [ROWS][tjsf_pkg::JOINTS];
  logic signed [tjsf_pkg::PV_W-1:0]   pv [ROWS][tjsf_pkg::JOINTS];
  logic signed [tjsf_pkg::ACC_W-1:0]  sum_pos [ROWS];
  logic signed [tjsf_pkg::ACC_W-1:0]  sum_vel [ROWS];
  logic signed [tjsf_pkg::ACC_W-1:0]  acc [ROWS];

  logic signed [tjsf_pkg::EFFORT_W-1:0] eff_next [ROWS];
  logic                                 clip_next [ROWS];

  // Unpack state and gain rows
  always_comb begin
    pos_a[0] = in_state.pos_one;
    pos_a[1] = in_state.pos_two;
    vel_a[0] = in_state.vel_one;
    vel_a[1] = in_state.vel_two;
    for (int r = 0; r < ROWS; r++) begin
      for (int t = 0; t < tjsf_pkg::GAINS_PER_ROW; t++) begin
        g[r][t] = $signed(gains[tjsf_pkg::REG_IDX_W'(r * tjsf_pkg::GAINS_PER_ROW + t)]);
      end
    end
  end

  // Round to nearest, ties toward plus infinity, after negation, then clamp
  always_comb begin
    logic signed [tjsf_pkg::ACC_W-1:0] negb;
    logic signed [tjsf_pkg::ACC_W-1:0] rs;
    negb = '0;
    rs   = '0;
    for (int r = 0; r < ROWS; r++) begin
      negb = tjsf_pkg::ACC_W'(tjsf_pkg::ROUND_BIAS) - acc[r];
      rs   = negb >>> tjsf_pkg::ROUND_SHIFT;
      if (rs > tjsf_pkg::ACC_W'(tjsf_pkg::EFFORT_MAX)) begin
        eff_next[r]  = tjsf_pkg::EFFORT_W'(tjsf_pkg::EFFORT_MAX);
        clip_next[r] = 1'b1;
      end else if (rs < tjsf_pkg::ACC_W'(tjsf_pkg::EFFORT_MIN)) begin
        eff_next[r]  = tjsf_pkg::EFFORT_W'(tjsf_pkg::EFFORT_MIN);
        clip_next[r] = 1'b1;
      end else begin
        eff_next[r]  = rs[tjsf_pkg::EFFORT_W-1:0];
        clip_next[r] = 1'b0;
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  // Products, partial sums, total, result
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < ROWS; r++) begin
        pp[r][0]   <= g[r][tjsf_pkg::TERM_POS1] * pos_a[0];
        pp[r][1]   <= g[r][tjsf_pkg::TERM_POS2] * pos_a[1];
        pv[r][0]   <= g[r][tjsf_pkg::TERM_VEL1] * vel_a[0];
        pv[r][1]   <= g[r][tjsf_pkg::TERM_VEL2] * vel_a[1];
        sum_pos[r] <= tjsf_pkg::ACC_W'(pp[r][0]) + tjsf_pkg::ACC_W'(pp[r][1]);
        sum_vel[r] <= (tjsf_pkg::ACC_W'(pv[r][0]) + tjsf_pkg::ACC_W'(pv[r][1]))
                      <<< tjsf_pkg::VEL_ALIGN;
        acc[r]     <= sum_pos[r] + sum_vel[r];
      end
      out_res.effort_one <= eff_next[0];
      out_res.effort_two <= eff_next[1];
      out_res.clipped    <= clip_next[0] | clip_next[1];
    end
  end

endmodule

>>> rtl/core/tjsf_skid.sv
// ----------------------------------------------------------------------------
// tjsf_skid
// Output register plus one spare entry; the pipeline advance is registered
// so the downstream ready never reaches the input side combinationally.
// ----------------------------------------------------------------------------
module tjsf_skid (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  tjsf_pkg::res_t  in_res,
  output logic            adv,
  output logic            out_valid,
  input  logic            out_ready,
  output tjsf_pkg::res_t  out_res
);

  logic           spare_valid;
  tjsf_pkg::res_t spare;
  logic           take;
  logic           push;

  assign adv  = !spare_valid;
  assign take = out_valid && out_ready;
  assign push = in_valid && adv;

  // Control: output slot and spare occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      spare_valid <= 1'b0;
    end else if (spare_valid) begin
      if (take) begin
        spare_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !take) begin
        spare_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  // Data: refill from spare first, else from the pipeline
  always_ff @(posedge clk) begin
    if (spare_valid) begin
      if (take) begin
        out_res <= spare;
      end
    end else if (push) begin
      if (out_valid && !take) begin
        spare <= in_res;
      end else begin
        out_res <= in_res;
      end
    end
  end

endmodule

>>> rtl/core/two_joint_state_feedback.sv
// ----------------------------------------------------------------------------
// two_joint_state_feedback
// Two-joint state-feedback controller with a 2x4 gain matrix.
// ----------------------------------------------------------------------------
// Beats pass the four-stage front end, eight-stage divider (four quotient
// bits per stage), velocity stage, four-stage gain multiply-accumulate and
// output register. The eight gains are written on the cfg port (index 0..7 as
// u1_pos1, u1_pos2, u1_vel1, u1_vel2, u2_pos1, u2_pos2, u2_vel1, u2_vel2,
// Q10.14, reset 0); the user must write them only while the block holds no
// items, which the block does not enforce. One item per clock is accepted
// while s_tready is high; it is low while the output register and spare entry
// are both full and rises in the cycle after the sink takes a beat.
`include "assert_macros.svh"

module two_joint_state_feedback (
  input  logic                            clk,
  input  logic                            rst,
  // config write port
  input  logic                            cfg_we,
  input  logic [tjsf_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [tjsf_pkg::GAIN_W-1:0]     cfg_data,
  // input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // angle_one, angle_two, rate_one, rate_two, target_one, target_two,
  // period_us, 4 bits zero pad
  input  logic [127:0]                    s_tdata,
  // output stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // effort_one, effort_two
  output logic [2*tjsf_pkg::EFFORT_W-1:0] m_tdata,
  // clipped
  output logic                            m_tuser
);

  localparam int A1_LSB = 0;
  localparam int A2_LSB = A1_LSB + tjsf_pkg::ANGLE_W;
  localparam int R1_LSB = A2_LSB + tjsf_pkg::ANGLE_W;
  localparam int R2_LSB = R1_LSB + tjsf_pkg::RATE_W;
  localparam int T1_LSB = R2_LSB + tjsf_pkg::RATE_W;
  localparam int T2_LSB = T1_LSB + tjsf_pkg::ANGLE_W;
  localparam int P_LSB  = T2_LSB + tjsf_pkg::ANGLE_W;

  localparam logic [tjsf_pkg::EFFORT_W-1:0] EFF_HI =
    tjsf_pkg::EFFORT_W'(tjsf_pkg::EFFORT_MAX);
  localparam logic [tjsf_pkg::EFFORT_W-1:0] EFF_LO =
    tjsf_pkg::EFFORT_W'(tjsf_pkg::EFFORT_MIN);

  tjsf_pkg::gain_bank_t gains;
  tjsf_pkg::in_item_t   in_item;
  tjsf_pkg::div_in_t    div_in;
  tjsf_pkg::state_t     state;
  tjsf_pkg::res_t       res;
  tjsf_pkg::res_t       out_res;

  logic adv;
  logic front_valid;
  logic div_valid;
  logic eff_valid;
  logic at_rail;

  // Gain registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gains <= '0;
    end else if (cfg_we) begin
      gains[cfg_index] <= cfg_data;
    end
  end

  // Unpack the input beat
  always_comb begin
    in_item.angle_one  = s_tdata[A1_LSB +: tjsf_pkg::ANGLE_W];
    in_item.angle_two  = s_tdata[A2_LSB +: tjsf_pkg::ANGLE_W];
    in_item.rate_one   = s_tdata[R1_LSB +: tjsf_pkg::RATE_W];
    in_item.rate_two   = s_tdata[R2_LSB +: tjsf_pkg::RATE_W];
    in_item.target_one = s_tdata[T1_LSB +: tjsf_pkg::ANGLE_W];
    in_item.target_two = s_tdata[T2_LSB +: tjsf_pkg::ANGLE_W];
    in_item.period_us  = s_tdata[P_LSB +: tjsf_pkg::PERIOD_W];
  end

  assign s_tready = adv;

  tjsf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (s_tvalid),
    .in_item   (in_item),
    .out_valid (front_valid),
    .out_data  (div_in)
  );

  tjsf_rate_div u_rate_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (front_valid),
    .in_data   (div_in),
    .out_valid (div_valid),
    .out_state (state)
  );

  tjsf_effort u_effort (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .gains     (gains),
    .in_valid  (div_valid),
    .in_state  (state),
    .out_valid (eff_valid),
    .out_res   (res)
  );

  tjsf_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (eff_valid),
    .in_res    (res),
    .adv       (adv),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  // Pack the result beat
  assign m_tdata = {out_res.effort_two, out_res.effort_one};
  assign m_tuser = out_res.clipped;

  // Flag an effort sitting on either rail
  assign at_rail = (out_res.effort_one == EFF_HI) || (out_res.effort_one == EFF_LO) ||
                   (out_res.effort_two == EFF_HI) || (out_res.effort_two == EFF_LO);

  // A full spare entry always sits behind a presented result
  `ASSERT_IMPLY(a_spare_behind_out, clk, rst, !s_tready, m_tvalid)
  // The spare entry drains on the first taken beat
  `ASSERT_NEXT(a_spare_drains, clk, rst, !s_tready && m_tready, s_tready)
  // A clipped result carries at least one effort at a rail
  `ASSERT_IMPLY(a_clip_at_rail, clk, rst, m_tvalid && m_tuser, at_rail)

endmodule
